// File: sv/phcc_pkg.sv
// ----------------------------------------------------------------------------
// phcc_pkg
// Shared constants for the packet header build / check block: CRC-8
// parameters, stream widths and default timing constants.
// ----------------------------------------------------------------------------
package phcc_pkg;

   // crc-8, polynomial x^8+x^7+x^5+x^2+x+1, msb first, zero init
   localparam int unsigned CRC_W       = 8;
   localparam int unsigned CRC_MSG_W   = 56;
   localparam logic [7:0]  CRC_POLY_LOW = 8'hA7;

   // header fields
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned PATTERN_W = 9;

   // item kind on req_tuser
   localparam logic KIND_CHECK = 1'b0;
   localparam logic KIND_BUILD = 1'b1;

   // time delay: residue of one orbit plus three bits of orbit-of-eight
   localparam int unsigned RES_W        = 12;
   localparam int unsigned TIME_DELAY_W = 15;

   // crossings per orbit, default
   localparam int unsigned ORBIT_CROSSINGS_DEF = 3564;

   // stream widths, padded to whole bytes
   localparam int unsigned REQ_TDATA_W = 176;
   localparam int unsigned RSP_TDATA_W = 136;

endpackage

// File: sv/phcc_crc8.sv
// ----------------------------------------------------------------------------
// phcc_crc8
// CRC-8 (0x1A7, msb first, zero init, no final xor) over a 56-bit message,
// computed as one xor tree of per-bit constant columns.
// ----------------------------------------------------------------------------
module phcc_crc8 (
   input  logic [phcc_pkg::CRC_MSG_W-1:0] msg_in,
   output logic [phcc_pkg::CRC_W-1:0]     crc_out
);
   import phcc_pkg::*;

   // crc of a message with only bit pos set, worked out at elaboration
   function automatic logic [CRC_W-1:0] crc_column(int unsigned pos);
      logic [CRC_MSG_W-1:0] m;
      logic [CRC_W-1:0]     c;
      logic                 fb;
      m = '0;
      m[pos] = 1'b1;
      c = '0;
      for (int i = CRC_MSG_W - 1; i >= 0; i--) begin
         fb = c[CRC_W-1] ^ m[i];
         c  = {c[CRC_W-2:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY_LOW;
         end
      end
      return c;
   endfunction

   logic [CRC_W-1:0] column_masked [CRC_MSG_W];

   // mask each constant column with its message bit
   for (genvar j = 0; j < CRC_MSG_W; j++) begin : g_col
      localparam logic [CRC_W-1:0] COL = crc_column(j);
      assign column_masked[j] = msg_in[j] ? COL : '0;
   end

   // xor all masked columns
   always_comb begin
      crc_out = '0;
      for (int j = 0; j < CRC_MSG_W; j++) begin
         crc_out = crc_out ^ column_masked[j];
      end
   end

endmodule

// File: sv/packet_header_crc_codec.sv
// ----------------------------------------------------------------------------
// packet_header_crc_codec
// Builds or checks a two-word packet header with a CRC-8 in the low byte,
// decodes its fields and gives the crossing delay modulo eight orbits.
// ----------------------------------------------------------------------------
//
//  channel  dir  ports                          item
//  req      in   req_tvalid/tready/tdata/tuser  header words or fields, kind
//  rsp      out  rsp_tvalid/tready/tdata        words, decoded fields, delay
//  csr      in   csr_valid/ready/wdata          header pattern register
//
//  One item per cycle unless rsp_tready stalls; items pass the delay path
//  stages: header time, subtract, modular fold products, fold sum,
//  reciprocal multiply, back multiply, correction and output register.
//  Reset clears the stage valid bits and the pattern register only.
//  Each stage moves when it is empty or the stage after it moves, so
//  bubbles are filled while a result waits on rsp_tready; nothing is
//  dropped or repeated under stalls.
//
module packet_header_crc_codec #(
   parameter int unsigned ORBIT_CROSSINGS = phcc_pkg::ORBIT_CROSSINGS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // csr write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [phcc_pkg::PATTERN_W-1:0]     csr_wdata,   // header_pattern
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // raw_first_word[31:0], raw_second_word[63:32], current_crossing[127:64],
   // length_in[136:128], flags_in[144:137], dtype_in[145], orbit_in[148:146],
   // event_in[154:149], bunch_in[166:155], reset_req_in[168:167], zero pad
   input  logic [phcc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tuser,   // kind
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // first_word_out[31:0], second_word_out[63:32], pattern_out[72:64],
   // length_out[81:73], flags_out[89:82], dtype_out[90], orbit_out[93:91],
   // event_out[99:94], bunch_out[111:100], reset_req_out[113:112],
   // crc_ok[114], time_delay[129:115], zero pad
   output logic [phcc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import phcc_pkg::*;

   localparam int unsigned N_STAGES = 7;
   localparam int unsigned CHUNK_W  = 12;
   localparam int unsigned N_CHUNKS = 6;
   localparam int unsigned FOLD_W   = 27;
   localparam int unsigned RECIP_SH = 27;
   localparam int unsigned REM_W    = 14;

   // 2^(12k) mod orbit, for folding the 61-bit quotient by eight
   localparam logic [CHUNK_W-1:0] FOLD [N_CHUNKS] = '{
      CHUNK_W'((64'd1 <<  0) % ORBIT_CROSSINGS),
      CHUNK_W'((64'd1 << 12) % ORBIT_CROSSINGS),
      CHUNK_W'((64'd1 << 24) % ORBIT_CROSSINGS),
      CHUNK_W'((64'd1 << 36) % ORBIT_CROSSINGS),
      CHUNK_W'((64'd1 << 48) % ORBIT_CROSSINGS),
      CHUNK_W'((64'd1 << 60) % ORBIT_CROSSINGS)
   };
   // reciprocal of the orbit length, estimate is low by at most one
   localparam logic [RECIP_SH:0] RECIP =
      (RECIP_SH+1)'((64'd1 << RECIP_SH) / ORBIT_CROSSINGS);
   localparam logic [12:0]      OC13  = 13'(ORBIT_CROSSINGS);
   localparam logic [REM_W-1:0] OC_REM = REM_W'(ORBIT_CROSSINGS);

   typedef struct packed {
      logic [WORD_W-1:0] first_word;
      logic [WORD_W-1:0] second_word;
      logic              crc_ok;
      logic [2:0]        low3;
   } hdr_type;

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   logic [PATTERN_W-1:0] header_pattern_ff, header_pattern_in;

   assign csr_ready = 1'b1;
   assign header_pattern_in = csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pattern_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         header_pattern_ff <= header_pattern_in;
      end
   end

   // ------------------------------------------------------------------
   // stage valid bits and moves
   // ------------------------------------------------------------------
   logic [N_STAGES-1:0] stage_valid_ff, stage_valid_in;
   logic [N_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[N_STAGES-1] = !stage_valid_ff[N_STAGES-1] || rsp_tready;
      for (int k = N_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !stage_valid_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      stage_valid_in[0] = stage_en[0] ? req_tvalid : stage_valid_ff[0];
      for (int k = 1; k < N_STAGES; k++) begin
         stage_valid_in[k] = stage_en[k] ? stage_valid_ff[k-1] : stage_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign req_tready = stage_en[0];

   // ------------------------------------------------------------------
   // stage 1: assemble words, header time
   // ------------------------------------------------------------------
   logic              in_build;
   logic [8:0]        in_length;
   logic [7:0]        in_flags;
   logic              in_dtype;
   logic [WORD_W-1:0] build_first, build_second;

   logic              st1_kind_ff, st1_kind_in;
   logic [WORD_W-1:0] st1_first_ff, st1_first_in;
   logic [WORD_W-1:0] st1_second_ff, st1_second_in;
   logic [63:0]       st1_cross_ff, st1_cross_in;
   logic [15:0]       st1_htime_ff, st1_htime_in;

   assign in_build  = (req_tuser == KIND_BUILD);
   assign in_length = req_tdata[136:128];
   assign in_flags  = req_tdata[144:137];
   // zero length marks a truncated packet
   assign in_dtype  = (in_length == '0) ? 1'b1 : req_tdata[145];

   assign build_first  = {header_pattern_ff, in_length, in_flags[6:0], in_dtype, 6'b0};
   assign build_second = {req_tdata[166:155], req_tdata[154:149], req_tdata[148:146],
                          in_flags[7], req_tdata[168:167], 8'h00};

   assign st1_kind_in   = in_build;
   assign st1_first_in  = in_build ? build_first  : req_tdata[31:0];
   assign st1_second_in = in_build ? build_second : req_tdata[63:32];
   assign st1_cross_in  = req_tdata[127:64];
   assign st1_htime_in  = 16'(ORBIT_CROSSINGS) * 16'(st1_second_in[13:11])
                        + 16'(st1_second_in[31:20]);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         st1_kind_ff   <= st1_kind_in;
         st1_first_ff  <= st1_first_in;
         st1_second_ff <= st1_second_in;
         st1_cross_ff  <= st1_cross_in;
         st1_htime_ff  <= st1_htime_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: crc and crossing difference
   // ------------------------------------------------------------------
   logic [CRC_W-1:0] crc_calc;

   phcc_crc8 u_crc (
      .msg_in  ({st1_first_ff, st1_second_ff[WORD_W-1:CRC_W]}),
      .crc_out (crc_calc)
   );

   hdr_type     st2_hdr_ff, st2_hdr_in;
   logic [63:0] st2_diff_ff, st2_diff_in;

   always_comb begin
      st2_diff_in            = st1_cross_ff - 64'(st1_htime_ff);
      st2_hdr_in.first_word  = st1_first_ff;
      st2_hdr_in.second_word = st1_kind_ff ? {st1_second_ff[WORD_W-1:CRC_W], crc_calc}
                                           : st1_second_ff;
      st2_hdr_in.crc_ok      = st1_kind_ff || (st1_second_ff[CRC_W-1:0] == crc_calc);
      st2_hdr_in.low3        = st2_diff_in[2:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         st2_hdr_ff  <= st2_hdr_in;
         st2_diff_ff <= st2_diff_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: fold products of the difference divided by eight
   // ------------------------------------------------------------------
   logic [CHUNK_W*N_CHUNKS-1:0] quot8;
   hdr_type                     st3_hdr_ff;
   logic [2*CHUNK_W-1:0]        st3_prod_ff [N_CHUNKS];
   logic [2*CHUNK_W-1:0]        st3_prod_in [N_CHUNKS];

   assign quot8 = (CHUNK_W*N_CHUNKS)'(st2_diff_ff[63:3]);

   always_comb begin
      for (int k = 0; k < N_CHUNKS; k++) begin
         st3_prod_in[k] = (2*CHUNK_W)'(quot8[k*CHUNK_W +: CHUNK_W])
                        * (2*CHUNK_W)'(FOLD[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         st3_hdr_ff  <= st2_hdr_ff;
         st3_prod_ff <= st3_prod_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: fold sum
   // ------------------------------------------------------------------
   hdr_type           st4_hdr_ff;
   logic [FOLD_W-1:0] st4_fold_ff, st4_fold_in;

   always_comb begin
      st4_fold_in = '0;
      for (int k = 0; k < N_CHUNKS; k++) begin
         st4_fold_in = st4_fold_in + FOLD_W'(st3_prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         st4_hdr_ff  <= st3_hdr_ff;
         st4_fold_ff <= st4_fold_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: quotient estimate by reciprocal
   // ------------------------------------------------------------------
   logic [FOLD_W+RECIP_SH:0] recip_prod;
   hdr_type                  st5_hdr_ff;
   logic [FOLD_W-1:0]        st5_fold_ff;
   logic [FOLD_W-1:0]        st5_quot_ff, st5_quot_in;

   assign recip_prod  = (FOLD_W+RECIP_SH+1)'(st4_fold_ff) * (FOLD_W+RECIP_SH+1)'(RECIP);
   assign st5_quot_in = recip_prod[RECIP_SH +: FOLD_W];

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         st5_hdr_ff  <= st4_hdr_ff;
         st5_fold_ff <= st4_fold_ff;
         st5_quot_ff <= st5_quot_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: remainder estimate, below twice the orbit
   // ------------------------------------------------------------------
   logic [FOLD_W+12:0] back_prod;
   logic [FOLD_W-1:0]  rem_full;
   hdr_type            st6_hdr_ff;
   logic [REM_W-1:0]   st6_rem_ff, st6_rem_in;

   assign back_prod  = (FOLD_W+13)'(st5_quot_ff) * (FOLD_W+13)'(OC13);
   assign rem_full   = st5_fold_ff - back_prod[FOLD_W-1:0];
   assign st6_rem_in = rem_full[REM_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         st6_hdr_ff <= st5_hdr_ff;
         st6_rem_ff <= st6_rem_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 7: correction and output register
   // ------------------------------------------------------------------
   logic [REM_W-1:0]        rem_fix;
   hdr_type                 st7_hdr_ff;
   logic [TIME_DELAY_W-1:0] st7_delay_ff, st7_delay_in;

   assign rem_fix      = (st6_rem_ff >= OC_REM) ? (st6_rem_ff - OC_REM) : st6_rem_ff;
   assign st7_delay_in = {rem_fix[RES_W-1:0], st6_hdr_ff.low3};

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         st7_hdr_ff   <= st6_hdr_ff;
         st7_delay_ff <= st7_delay_in;
      end
   end

   // ------------------------------------------------------------------
   // response packing, fields decoded from the words
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] out_first, out_second;

   assign out_first  = st7_hdr_ff.first_word;
   assign out_second = st7_hdr_ff.second_word;
   assign rsp_tvalid = stage_valid_ff[N_STAGES-1];
   assign rsp_tdata  = {6'b0,
                        st7_delay_ff,
                        st7_hdr_ff.crc_ok,
                        out_second[9:8],
                        out_second[31:20],
                        out_second[19:14],
                        out_second[13:11],
                        out_first[6],
                        out_second[10], out_first[13:7],
                        out_first[22:14],
                        out_first[31:23],
                        out_second,
                        out_first};

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // quotient estimate never overshoots
   a_quot_low: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[4] |-> (back_prod[FOLD_W+12:0] <= (FOLD_W+13)'(st5_fold_ff)))
      else $error("reciprocal quotient too large");

   // remainder estimate stays below twice the orbit
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[5] |-> ((FOLD_W+1)'(st6_rem_ff) < (FOLD_W+1)'(2 * ORBIT_CROSSINGS)))
      else $error("remainder estimate out of range");

   // delivered residue is below one orbit
   a_delay_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (13'(st7_delay_ff[TIME_DELAY_W-1:3]) < OC13))
      else $error("time delay residue out of range");

   // an empty last stage lets the whole pipeline take an item
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff[N_STAGES-1] |-> req_tready)
      else $error("pipeline blocked with empty output stage");

   // a built header leaves stage two marked good
   a_build_ok: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff[0] && st1_kind_ff && stage_en[1]) |=> st2_hdr_ff.crc_ok)
      else $error("built header not marked good");

endmodule
